>>> sv/cle_pkg.sv
// shared types, constants and index helpers for the console line editor
package cle_pkg;

  // line store geometry, indices run modulo twice the depth
  localparam int STORE_DEPTH = 128;
  localparam int IDX_MOD     = 2 * STORE_DEPTH;
  localparam int IDX_W       = $clog2(IDX_MOD);
  localparam int SLOT_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // key codes
  localparam logic [7:0] KEY_NUL    = 8'h00;
  localparam logic [7:0] KEY_CTRL_B = 8'h02;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;
  localparam logic [7:0] KEY_TAB    = 8'h09;
  localparam logic [7:0] KEY_LF     = 8'h0A;
  localparam logic [7:0] KEY_CR     = 8'h0D;
  localparam logic [7:0] KEY_CTRL_O = 8'h0F;
  localparam logic [7:0] KEY_CTRL_P = 8'h10;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_ESC    = 8'h1B;
  localparam logic [7:0] KEY_DEL    = 8'h7F;
  localparam logic [7:0] PRINT_MIN  = 8'h20;
  localparam logic [7:0] PRINT_MAX  = 8'd126;
  localparam logic [7:0] ECHO_ESC   = 8'h5B;
  localparam logic [7:0] ECHO_TAB   = 8'h20;
  localparam logic [7:0] ECHO_BAD   = 8'h3F;

  // command codes
  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // debug request codes
  localparam logic [1:0] DBG_NONE  = 2'd0;
  localparam logic [1:0] DBG_PROCS = 2'd1;
  localparam logic [1:0] DBG_TRACE = 2'd2;
  localparam logic [1:0] DBG_SCHED = 2'd3;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DEBUG,
    OP_KILL,
    OP_ERASE,
    OP_STORE,
    OP_READ
  } op_code_t;

  // classified item handed from front to back
  typedef struct packed {
    op_code_t   op;
    logic [7:0] key;
    logic [7:0] echo;
    logic [1:0] dbg;
    logic       started;
  } op_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       line_ready;
    logic [1:0] debug_request;
    logic       key_dropped;
    logic       read_valid;
    logic [7:0] read_char;
    logic       read_eof;
    logic       read_empty;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KILL,
    ST_KILL_DONE,
    ST_READ
  } back_state_t;

  function automatic idx_t idx_inc(idx_t x);
    return (x == idx_t'(IDX_MOD - 1)) ? '0 : idx_t'(x + 1'b1);
  endfunction

  function automatic idx_t idx_dec(idx_t x);
    return (x == '0) ? idx_t'(IDX_MOD - 1) : idx_t'(x - 1'b1);
  endfunction

  function automatic idx_t idx_dist(idx_t a, idx_t b);
    logic [IDX_W:0] wrapped;
    wrapped = {1'b0, a} + (IDX_W + 1)'(IDX_MOD) - {1'b0, b};
    return (a >= b) ? idx_t'(a - b) : wrapped[IDX_W-1:0];
  endfunction

  function automatic slot_t idx_slot(idx_t x);
    return (x >= idx_t'(STORE_DEPTH)) ? slot_t'(x - idx_t'(STORE_DEPTH)) : slot_t'(x);
  endfunction

  function automatic logic [7:0] sat_erase(logic [CNT_W-1:0] n);
    return (n > CNT_W'(255)) ? 8'd255 : 8'(n);
  endfunction

endpackage

>>> sv/cle_ram.sv
// generic single write port ram with registered read
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/cle_front.sv
// front end: classifies an incoming item into an operation for the back end
module cle_front (
  input  logic         command,
  input  logic [7:0]   key_char,
  input  logic         read_started,
  output cle_pkg::op_t op
);

  logic [7:0] key_map;

  // carriage return is stored as line feed
  assign key_map = (key_char == cle_pkg::KEY_CR) ? cle_pkg::KEY_LF : key_char;

  always_comb begin
    op         = '0;
    op.op      = cle_pkg::OP_NONE;
    op.key     = key_map;
    op.started = read_started;
    op.dbg     = cle_pkg::DBG_NONE;

    // echo mapping
    if (key_map == cle_pkg::KEY_ESC) begin
      op.echo = cle_pkg::ECHO_ESC;
    end else if (key_map == cle_pkg::KEY_TAB) begin
      op.echo = cle_pkg::ECHO_TAB;
    end else if ((key_map < cle_pkg::PRINT_MIN || key_map > cle_pkg::PRINT_MAX) &&
                 key_map != cle_pkg::KEY_LF) begin
      op.echo = cle_pkg::ECHO_BAD;
    end else begin
      op.echo = key_map;
    end

    if (command == cle_pkg::CMD_READ) begin
      op.op = cle_pkg::OP_READ;
    end else begin
      priority if (key_char == cle_pkg::KEY_CTRL_P) begin
        op.op  = cle_pkg::OP_DEBUG;
        op.dbg = cle_pkg::DBG_PROCS;
      end else if (key_char == cle_pkg::KEY_CTRL_B) begin
        op.op  = cle_pkg::OP_DEBUG;
        op.dbg = cle_pkg::DBG_TRACE;
      end else if (key_char == cle_pkg::KEY_CTRL_O) begin
        op.op  = cle_pkg::OP_DEBUG;
        op.dbg = cle_pkg::DBG_SCHED;
      end else if (key_char == cle_pkg::KEY_CTRL_U) begin
        op.op = cle_pkg::OP_KILL;
      end else if (key_char == cle_pkg::KEY_CTRL_H || key_char == cle_pkg::KEY_DEL) begin
        op.op = cle_pkg::OP_ERASE;
      end else if (key_char != cle_pkg::KEY_NUL) begin
        op.op = cle_pkg::OP_STORE;
      end else begin
        op.op = cle_pkg::OP_NONE;
      end
    end
  end

endmodule

>>> sv/cle_queue.sv
// short fifo of classified operations between front and back
module cle_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  cle_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output cle_pkg::op_t head_op
);

  cle_pkg::op_t                entry_r [cle_pkg::QUEUE_DEPTH];
  logic [cle_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [cle_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [cle_pkg::QCNT_W-1:0]  count_r, count_nxt;

  assign full      = (count_r == cle_pkg::QCNT_W'(cle_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_op   = entry_r[rd_ptr_r];

  function automatic logic [cle_pkg::QPTR_W-1:0] ptr_inc(logic [cle_pkg::QPTR_W-1:0] p);
    return (p == cle_pkg::QPTR_W'(cle_pkg::QUEUE_DEPTH - 1)) ? '0 : cle_pkg::QPTR_W'(p + 1'b1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = cle_pkg::QCNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = cle_pkg::QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

>>> sv/cle_back.sv
// back end: executes operations on the line store and holds the result register
module cle_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          op_valid,
  input  cle_pkg::op_t  op,
  output logic          op_pop,
  output logic          res_valid,
  output cle_pkg::res_t res,
  input  logic          res_stall
);

  cle_pkg::back_state_t     st_r, st_nxt;
  cle_pkg::idx_t            rd_idx_r, rd_idx_nxt;
  cle_pkg::idx_t            cm_idx_r, cm_idx_nxt;
  cle_pkg::idx_t            ed_idx_r, ed_idx_nxt;
  logic [cle_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                     started_r, started_nxt;
  logic                     res_valid_r, res_valid_nxt;
  cle_pkg::res_t            res_r, res_nxt;

  logic                     res_room;
  logic                     load;
  cle_pkg::res_t            res_new;
  cle_pkg::idx_t            ed_dec;
  cle_pkg::idx_t            ed_inc;
  logic                     ram_we;
  cle_pkg::slot_t           ram_waddr;
  logic                     ram_re;
  cle_pkg::slot_t           ram_raddr;
  logic [7:0]               ram_rdata;

  cle_ram #(
    .WIDTH (8),
    .DEPTH (cle_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (op.key),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign res_room = !res_valid_r || !res_stall;
  assign ed_dec   = cle_pkg::idx_dec(ed_idx_r);
  assign ed_inc   = cle_pkg::idx_inc(ed_idx_r);

  always_comb begin
    st_nxt      = st_r;
    rd_idx_nxt  = rd_idx_r;
    cm_idx_nxt  = cm_idx_r;
    ed_idx_nxt  = ed_idx_r;
    cnt_nxt     = cnt_r;
    started_nxt = started_r;
    op_pop      = 1'b0;
    load        = 1'b0;
    res_new     = '0;
    ram_we      = 1'b0;
    ram_waddr   = cle_pkg::idx_slot(ed_idx_r);
    ram_re      = 1'b0;
    ram_raddr   = cle_pkg::idx_slot(ed_dec);

    unique case (st_r)
      cle_pkg::ST_IDLE: begin
        if (op_valid && res_room) begin
          op_pop = 1'b1;
          unique case (op.op)
            cle_pkg::OP_NONE: begin
              load = 1'b1;
            end
            cle_pkg::OP_DEBUG: begin
              load                  = 1'b1;
              res_new.debug_request = op.dbg;
            end
            cle_pkg::OP_ERASE: begin
              load = 1'b1;
              if (ed_idx_r != cm_idx_r) begin
                ed_idx_nxt          = ed_dec;
                res_new.erase_count = 8'd1;
              end
            end
            cle_pkg::OP_STORE: begin
              load = 1'b1;
              if (cle_pkg::idx_dist(ed_idx_r, rd_idx_r) < cle_pkg::idx_t'(cle_pkg::STORE_DEPTH))
              begin
                ram_we             = 1'b1;
                res_new.echo_valid = 1'b1;
                res_new.echo_char  = op.echo;
                ed_idx_nxt         = ed_inc;
                // line ends on newline, tab, end of file or a full store
                if (op.key == cle_pkg::KEY_LF || op.key == cle_pkg::KEY_TAB ||
                    op.key == cle_pkg::KEY_CTRL_D ||
                    cle_pkg::idx_dist(ed_inc, rd_idx_r) ==
                    cle_pkg::idx_t'(cle_pkg::STORE_DEPTH)) begin
                  cm_idx_nxt         = ed_inc;
                  res_new.line_ready = 1'b1;
                end
              end else begin
                res_new.key_dropped = 1'b1;
              end
            end
            cle_pkg::OP_KILL: begin
              if (ed_idx_r == cm_idx_r) begin
                load = 1'b1;
              end else begin
                ram_re  = 1'b1;
                cnt_nxt = '0;
                st_nxt  = cle_pkg::ST_KILL;
              end
            end
            cle_pkg::OP_READ: begin
              if (rd_idx_r == cm_idx_r) begin
                load               = 1'b1;
                res_new.read_empty = 1'b1;
              end else begin
                ram_re      = 1'b1;
                ram_raddr   = cle_pkg::idx_slot(rd_idx_r);
                started_nxt = op.started;
                st_nxt      = cle_pkg::ST_READ;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end

      // one stored character checked per cycle, walking back from the edit index
      cle_pkg::ST_KILL: begin
        if (ram_rdata == cle_pkg::KEY_LF) begin
          st_nxt = cle_pkg::ST_KILL_DONE;
        end else begin
          ed_idx_nxt = ed_dec;
          cnt_nxt    = cle_pkg::CNT_W'(cnt_r + 1'b1);
          if (ed_dec == cm_idx_r) begin
            st_nxt = cle_pkg::ST_KILL_DONE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = cle_pkg::idx_slot(cle_pkg::idx_dec(ed_dec));
          end
        end
      end

      cle_pkg::ST_KILL_DONE: begin
        if (res_room) begin
          load                = 1'b1;
          res_new.erase_count = cle_pkg::sat_erase(cnt_r);
          st_nxt              = cle_pkg::ST_IDLE;
        end
      end

      cle_pkg::ST_READ: begin
        if (res_room) begin
          load   = 1'b1;
          st_nxt = cle_pkg::ST_IDLE;
          if (ram_rdata == cle_pkg::KEY_CTRL_D) begin
            res_new.read_eof = 1'b1;
            if (!started_r) begin
              rd_idx_nxt = cle_pkg::idx_inc(rd_idx_r);
            end
          end else begin
            rd_idx_nxt         = cle_pkg::idx_inc(rd_idx_r);
            res_new.read_valid = 1'b1;
            res_new.read_char  = ram_rdata;
          end
        end
      end

      default: begin
        st_nxt = cle_pkg::ST_IDLE;
      end
    endcase

    if (load) begin
      res_valid_nxt = 1'b1;
      res_nxt       = res_new;
    end else begin
      res_valid_nxt = res_valid_r && res_stall;
      res_nxt       = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= cle_pkg::ST_IDLE;
      rd_idx_r    <= '0;
      cm_idx_r    <= '0;
      ed_idx_r    <= '0;
      res_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cm_idx_r    <= cm_idx_nxt;
      ed_idx_r    <= ed_idx_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    started_r <= started_nxt;
    res_r     <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

>>> sv/console_line_editor_core.sv
// top level of the console line editor: front, operation queue and back end
//
// usage
// - input channel (in_*): one transfer per key or read request; in_command
//   selects a key from the serial side or a read of one committed character
// - output channel (out_*): exactly one result transfer per input transfer,
//   in input order; fields of the other command read as zero
// - the front classifies each transfer and pushes it into a two-entry queue;
//   in_stall is high only while that queue is full
// - plain keys, erase and debug keys pass the queue entry register and the
//   result register; a read adds the registered line store read, and ctrl-u
//   erasing n characters (at most 127, one below the store depth since a
//   full store commits) adds a walk, one stored character checked per cycle
//   through the line store read port
// - throughput: one item per cycle for keys that do not read the store, while
//   out_stall is low; a read or ctrl-u ends before the next item is taken
// - out_stall holds the result register; the back end then stops, the queue
//   fills and in_stall rises, nothing is lost or repeated
// - reset (rst_n low, synchronous) zeroes the read, commit and edit indices
//   and empties the queue; store contents are not cleared, no entry is read
//   before it has been written
module console_line_editor_core (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [7:0] in_key_char,
  input  logic       in_read_started,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_echo_valid,
  output logic [7:0] out_echo_char,
  output logic [7:0] out_erase_count,
  output logic       out_line_ready,
  output logic [1:0] out_debug_request,
  output logic       out_key_dropped,
  output logic       out_read_valid,
  output logic [7:0] out_read_char,
  output logic       out_read_eof,
  output logic       out_read_empty
);

  cle_pkg::op_t  front_op;
  cle_pkg::op_t  head_op;
  logic          q_full;
  logic          q_not_empty;
  logic          q_pop;
  logic          in_xfer;
  cle_pkg::res_t res;

  assign in_stall = q_full;
  assign in_xfer  = in_valid && !q_full;

  // classify the incoming item
  cle_front u_front (
    .command      (in_command),
    .key_char     (in_key_char),
    .read_started (in_read_started),
    .op           (front_op)
  );

  // decouples input acceptance from store walks in the back end
  cle_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_op   (front_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_op   (head_op)
  );

  // line store, indices and result register
  cle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_not_empty),
    .op        (head_op),
    .op_pop    (q_pop),
    .res_valid (out_valid),
    .res       (res),
    .res_stall (out_stall)
  );

  assign out_echo_valid    = res.echo_valid;
  assign out_echo_char     = res.echo_char;
  assign out_erase_count   = res.erase_count;
  assign out_line_ready    = res.line_ready;
  assign out_debug_request = res.debug_request;
  assign out_key_dropped   = res.key_dropped;
  assign out_read_valid    = res.read_valid;
  assign out_read_char     = res.read_char;
  assign out_read_eof      = res.read_eof;
  assign out_read_empty    = res.read_empty;

`ifndef SYNTHESIS
  // a delivered character excludes end of file and empty
  a_read_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_valid |-> !out_read_eof && !out_read_empty)
    else $error("read result flags conflict");

  // a dropped key is never echoed nor commits a line
  a_drop_no_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_dropped |-> !out_echo_valid && !out_line_ready)
    else $error("dropped key echoed or committed");

  // a line is committed only by a stored, echoed key
  a_commit_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_ready |-> out_echo_valid)
    else $error("line committed without echo");

  // key results and read results never mix
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_echo_valid || out_erase_count != 8'd0 || out_key_dropped) |->
    !out_read_valid && !out_read_eof && !out_read_empty)
    else $error("key and read result mixed");
`endif

endmodule
